/* rtl/core/dsl_pkg.sv */
package dsl_pkg;

	localparam int POSITION_WIDTH_DEF = 16;
	localparam int DEPTH_WIDTH_DEF    = 8;
	localparam int OUT_WIDTH          = 16;
	localparam int KW_COUNT           = 14;

	localparam logic [4:0] KIND_END     = 5'd0;
	localparam logic [4:0] KIND_IDENT   = 5'd1;
	localparam logic [4:0] KIND_OPER    = 5'd2;
	localparam logic [4:0] KIND_NUMBER  = 5'd3;
	localparam logic [4:0] KIND_STRING  = 5'd4;
	localparam logic [4:0] KIND_EXPR    = 5'd5;
	localparam logic [4:0] KIND_KW_BASE = 5'd6;
	localparam logic [4:0] KIND_LPAREN  = 5'd20;
	localparam logic [4:0] KIND_RPAREN  = 5'd21;
	localparam logic [4:0] KIND_COLON   = 5'd22;
	localparam logic [4:0] KIND_COMMA   = 5'd23;
	localparam logic [4:0] KIND_SEMI    = 5'd24;
	localparam logic [4:0] KIND_ASSIGN  = 5'd25;

	localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
		80'("logic"), 80'("if"), 80'("else"), 80'("state"), 80'("transition"),
		80'("context"), 80'("rule"), 80'("execute"), 80'("result"),
		80'("terminate"), 80'("register"), 80'("constant"), 80'("push"), 80'("pop")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd2, 4'd4, 4'd5, 4'd10, 4'd7, 4'd4, 4'd7, 4'd6, 4'd9, 4'd8, 4'd8, 4'd4, 4'd3
	};

	typedef struct packed {
		logic [4:0]           kind;
		logic [OUT_WIDTH-1:0] line;
		logic [OUT_WIDTH-1:0] column;
		logic [OUT_WIDTH-1:0] length;
		logic                 last;
	} token_t;

	function automatic logic [7:0] kw_char(input int i, input logic [3:0] p);
		logic [79:0] t;
		int          l;
		t = KW_TEXT[i];
		l = int'(KW_LEN[i]);
		if (int'(p) < l) begin
			return t[(l - 1 - int'(p)) * 8 +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == "<" || c == ">" || c == "!" || c == "+" || c == "-" ||
			c == "*" || c == "/" || c == "%" || c == "&" || c == "|";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

endpackage

/* rtl/core/dsl_token_scanner.sv */
// Byte-serial token scanner for a small rule language.
// Input channel (in_valid/in_ready): one word per source byte in char_code;
// end_of_input or a zero byte closes any open token and emits the end token.
// Output channel (out_valid/out_ready): one word per token with kind, line,
// start column and length; last_of_run marks the final token caused by one
// input word. A word causes zero, one or two tokens.
// A finished token is written into the output queue when the word that
// completes it is accepted. Throughput: one input word per cycle while the
// queue has room; tokens leave at one per cycle while out_ready is high.
// Tokens wait in a three-entry output queue. A new word is taken while at
// least two entries are free after this cycle's pop, so a stalled receiver
// blocks input only once the queue holds two or more tokens.
// After the end token every further input word is taken and dropped.
// Reset (arst_n low) empties the queue and returns the scanner to line 1,
// column 1, no open token.
module dsl_token_scanner
	import dsl_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
	parameter int DEPTH_WIDTH    = DEPTH_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_code,
	input  logic                 end_of_input,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [4:0]           token_kind,
	output logic [OUT_WIDTH-1:0] token_line,
	output logic [OUT_WIDTH-1:0] start_column,
	output logic [OUT_WIDTH-1:0] token_length,
	output logic                 last_of_run
);

	localparam int PW = POSITION_WIDTH;
	localparam int DW = DEPTH_WIDTH;
	localparam int WW = (PW > OUT_WIDTH) ? PW : OUT_WIDTH;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_SYMBOL, MODE_STRING, MODE_EXPR
	} mode_t;

	mode_t                mode_q;
	logic [PW-1:0]        line_q, col_q, start_q, len_q, trail_q;
	logic [DW-1:0]        depth_q;
	logic [KW_COUNT-1:0]  cand_q;
	logic                 fin_q;

	mode_t                mode_d;
	logic [PW-1:0]        line_d, col_d, start_d, len_d, trail_d;
	logic [DW-1:0]        depth_d;
	logic [KW_COUNT-1:0]  cand_d;
	logic                 fin_d;

	token_t               res [2];
	logic [1:0]           n_res;

	token_t               q_q [3];
	token_t               q_d [3];
	logic [1:0]           cnt_q;
	logic                 pop, fire;
	logic [1:0]           base;

	function automatic logic [PW-1:0] inc_p(input logic [PW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [PW-1:0] v);
		logic [WW-1:0] t;
		t = WW'(v);
		return t[OUT_WIDTH-1:0];
	endfunction

	always_comb begin
		logic [7:0]     c;
		logic           endm, cl, idl, post_inc;
		logic [3:0]     p;
		logic [4:0]     k, punct;
		logic [PW-1:0]  l;
		logic [DW-1:0]  dd;
		c        = char_code;
		endm     = end_of_input || c == 8'h00;
		cl       = 1'b0;
		idl      = 1'b0;
		post_inc = 1'b0;
		mode_d   = mode_q;
		line_d   = line_q;
		col_d    = col_q;
		start_d  = start_q;
		len_d    = len_q;
		trail_d  = trail_q;
		depth_d  = depth_q;
		cand_d   = cand_q;
		fin_d    = fin_q;
		n_res    = 2'd0;
		res[0]   = '0;
		res[1]   = '0;
		p        = (len_q < PW'(10)) ? len_q[3:0] : 4'd15;
		dd       = '0;
		k        = KIND_END;
		l        = len_q;
		punct    = KIND_END;
		if (!fin_q) begin
			if (endm) begin
				cl = 1'b1;
			end else begin
				unique case (mode_q)
					MODE_IDENT: begin
						if (is_alpha(c) || is_digit(c) || c == "_" || c == "-") begin
							for (int i = 0; i < KW_COUNT; i++) begin
								if (kw_char(i, p) != c) cand_d[i] = 1'b0;
							end
							len_d = inc_p(len_q);
							col_d = inc_p(col_q);
						end else begin
							cl  = 1'b1;
							idl = 1'b1;
						end
					end
					MODE_NUMBER: begin
						if (is_digit(c) || c == ".") begin
							len_d = inc_p(len_q);
							col_d = inc_p(col_q);
						end else begin
							cl  = 1'b1;
							idl = 1'b1;
						end
					end
					MODE_SYMBOL: begin
						if (is_op(c)) begin
							len_d = inc_p(len_q);
							col_d = inc_p(col_q);
						end else begin
							cl  = 1'b1;
							idl = 1'b1;
						end
					end
					MODE_STRING: begin
						if (c == "'") begin
							cl       = 1'b1;
							post_inc = 1'b1;
						end else begin
							len_d = inc_p(len_q);
							if (c == 8'h0a) begin
								line_d = inc_p(line_q);
								col_d  = PW'(1);
							end else begin
								col_d = inc_p(col_q);
							end
						end
					end
					MODE_EXPR: begin
						dd = (depth_q != '0) ? depth_q - 1'b1 : '0;
						if (c == "}" && dd == '0) begin
							depth_d  = dd;
							cl       = 1'b1;
							post_inc = 1'b1;
						end else begin
							if (c == "{") depth_d = (&depth_q) ? depth_q : depth_q + 1'b1;
							else if (c == "}") depth_d = dd;
							if (c == " " || (c >= 8'd9 && c <= 8'd13)) trail_d = inc_p(trail_q);
							else trail_d = '0;
							len_d = inc_p(len_q);
							if (c == 8'h0a) begin
								line_d = inc_p(line_q);
								col_d  = PW'(1);
							end else begin
								col_d = inc_p(col_q);
							end
						end
					end
					default: begin
						idl = 1'b1;
					end
				endcase
			end
			if (cl && mode_q != MODE_IDLE) begin
				unique case (mode_q)
					MODE_IDENT: begin
						k = KIND_IDENT;
						for (int i = 0; i < KW_COUNT; i++) begin
							if (cand_q[i] && len_q == PW'(KW_LEN[i])) k = KIND_KW_BASE + 5'(i);
						end
					end
					MODE_NUMBER: k = KIND_NUMBER;
					MODE_SYMBOL: k = KIND_OPER;
					MODE_STRING: k = KIND_STRING;
					MODE_EXPR: begin
						k = KIND_EXPR;
						l = (len_q >= trail_q) ? len_q - trail_q : '0;
					end
					default: k = KIND_END;
				endcase
				res[0] = '{kind: k, line: to_out(line_q), column: to_out(start_q),
					length: to_out(l), last: 1'b0};
				n_res  = 2'd1;
				mode_d = MODE_IDLE;
			end
			if (post_inc) col_d = inc_p(col_q);
			if (endm) begin
				res[n_res[0]] = '{kind: KIND_END, line: to_out(line_q),
					column: to_out(col_q), length: '0, last: 1'b0};
				n_res = n_res + 2'd1;
				fin_d = 1'b1;
			end
			if (idl) begin
				mode_d = MODE_IDLE;
				if (c == " " || c == 8'h09 || c == 8'h0d) begin
					col_d = inc_p(col_q);
				end else if (c == 8'h0a) begin
					line_d = inc_p(line_q);
					col_d  = PW'(1);
				end else if (is_alpha(c) || c == "_" || is_digit(c) || c == "'" ||
						c == "{" || is_op(c)) begin
					start_d = col_q;
					col_d   = inc_p(col_q);
					len_d   = PW'(1);
					if (is_alpha(c) || c == "_") begin
						mode_d = MODE_IDENT;
						for (int i = 0; i < KW_COUNT; i++) begin
							cand_d[i] = (kw_char(i, 4'd0) == c);
						end
					end else if (is_digit(c)) begin
						mode_d = MODE_NUMBER;
					end else if (c == "'") begin
						mode_d = MODE_STRING;
						len_d  = '0;
					end else if (c == "{") begin
						mode_d  = MODE_EXPR;
						len_d   = '0;
						depth_d = DW'(1);
						trail_d = '0;
					end else begin
						mode_d = MODE_SYMBOL;
					end
				end else begin
					unique case (c)
						"(":     punct = KIND_LPAREN;
						")":     punct = KIND_RPAREN;
						":":     punct = KIND_COLON;
						",":     punct = KIND_COMMA;
						";":     punct = KIND_SEMI;
						"=":     punct = KIND_ASSIGN;
						default: punct = KIND_END;
					endcase
					if (punct != KIND_END) begin
						res[n_res[0]] = '{kind: punct, line: to_out(line_q),
							column: to_out(col_q), length: OUT_WIDTH'(1), last: 1'b0};
						n_res = n_res + 2'd1;
					end
					col_d = inc_p(col_q);
				end
			end
			if (n_res == 2'd1) res[0].last = 1'b1;
			if (n_res == 2'd2) res[1].last = 1'b1;
		end
	end

	assign pop      = out_valid && out_ready;
	assign base     = cnt_q - {1'b0, pop};
	assign in_ready = base <= 2'd1;
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			line_q  <= PW'(1);
			col_q   <= PW'(1);
			start_q <= '0;
			len_q   <= '0;
			trail_q <= '0;
			depth_q <= '0;
			cand_q  <= '1;
			fin_q   <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (fire) begin
				mode_q  <= mode_d;
				line_q  <= line_d;
				col_q   <= col_d;
				start_q <= start_d;
				len_q   <= len_d;
				trail_q <= trail_d;
				depth_q <= depth_d;
				cand_q  <= cand_d;
				fin_q   <= fin_d;
			end
			cnt_q <= base + (fire ? n_res : 2'd0);
		end
	end

	always_comb begin
		q_d = q_q;
		if (pop) begin
			q_d[0] = q_q[1];
			q_d[1] = q_q[2];
		end
		if (fire && n_res != 2'd0) q_d[base] = res[0];
		if (fire && n_res == 2'd2) q_d[base + 2'd1] = res[1];
	end

	always_ff @(posedge clk) begin
		q_q <= q_d;
	end

	assign out_valid    = cnt_q != 2'd0;
	assign token_kind   = q_q[0].kind;
	assign token_line   = q_q[0].line;
	assign start_column = q_q[0].column;
	assign token_length = q_q[0].length;
	assign last_of_run  = q_q[0].last;

endmodule

/* rtl/core/dsl_checker.sv */
module dsl_checker
	import dsl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [4:0]           token_kind,
	input logic [OUT_WIDTH-1:0] token_line,
	input logic [OUT_WIDTH-1:0] start_column,
	input logic [OUT_WIDTH-1:0] token_length,
	input logic                 last_of_run
);

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (out_valid && out_ready && token_kind == KIND_END) begin
			done_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(token_line) && $stable(start_column) && $stable(token_length))
		else $error("stalled word changed");

	a_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !out_valid)
		else $error("word after end token");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_END |-> token_length == '0 && last_of_run)
		else $error("bad end token");

	a_punct_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind >= KIND_LPAREN |->
		token_length == OUT_WIDTH'(1) && token_line != '0 && start_column != '0)
		else $error("bad punctuator token");

endmodule

bind dsl_token_scanner dsl_checker u_dsl_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
	.token_line(token_line), .start_column(start_column),
	.token_length(token_length), .last_of_run(last_of_run)
);

/* sim/token_checker.sv */
module token_checker
	import dsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           char_code,
	input  logic                 end_of_input,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [4:0]           token_kind,
	input  logic [OUT_WIDTH-1:0] token_line,
	input  logic [OUT_WIDTH-1:0] start_column,
	input  logic [OUT_WIDTH-1:0] token_length,
	input  logic                 last_of_run,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {S_IDLE, S_IDENT, S_NUM, S_OPS, S_STR, S_EXPR} scan_e;

	localparam logic [15:0] POS_MAX   = 16'hFFFF;
	localparam logic [7:0]  DEPTH_MAX = 8'hFF;

	string kw_word [KW_COUNT] = '{"logic", "if", "else", "state", "transition", "context",
		"rule", "execute", "result", "terminate", "register", "constant", "push", "pop"};

	scan_e       mode;
	logic [15:0] line_n, col_n, start_col, tok_len, trail;
	logic [7:0]  depth;
	logic [13:0] cand;
	logic        done;
	token_t      run_q[$];
	token_t      token_q[$];

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return v == POS_MAX ? v : v + 16'd1;
	endfunction

	function automatic logic is_op_byte(input logic [7:0] c);
		return c == "<" || c == ">" || c == "!" || c == "+" || c == "-" ||
			c == "*" || c == "/" || c == "%" || c == "&" || c == "|";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic put_token(input logic [4:0] k, input logic [15:0] l, input logic [15:0] c,
		input logic [15:0] n);
		token_t t;
		t = '{kind: k, line: l, column: c, length: n, last: 1'b0};
		if (run_q.size() < 2) run_q.push_back(t);
	endtask

	task automatic narrow(input logic [7:0] c);
		for (int i = 0; i < KW_COUNT; i++) begin
			if (tok_len >= kw_word[i].len() || kw_word[i][tok_len] != c) cand[i] = 1'b0;
		end
	endtask

	task automatic close_token();
		logic [4:0]  k;
		logic [15:0] n;
		n = tok_len;
		case (mode)
			S_IDENT: begin
				k = KIND_IDENT;
				for (int i = 0; i < KW_COUNT; i++)
					if (cand[i] && kw_word[i].len() == tok_len) k = KIND_KW_BASE + 5'(i);
			end
			S_NUM: k = KIND_NUMBER;
			S_OPS: k = KIND_OPER;
			S_STR: k = KIND_STRING;
			S_EXPR: begin
				k = KIND_EXPR;
				n = tok_len >= trail ? tok_len - trail : 16'd0;
			end
			default: return;
		endcase
		put_token(k, line_n, start_col, n);
		mode = S_IDLE;
	endtask

	task automatic open_token(input scan_e m, input logic [15:0] n);
		mode = m;
		start_col = col_n;
		tok_len = n;
		col_n = inc16(col_n);
	endtask

	task automatic idle_byte(input logic [7:0] c);
		logic [4:0] p;
		p = KIND_END;
		if (c == " " || c == 8'h09 || c == 8'h0D) begin
			col_n = inc16(col_n);
		end else if (c == 8'h0A) begin
			line_n = inc16(line_n);
			col_n = 16'd1;
		end else if (is_letter(c) || c == "_") begin
			cand = '1;
			tok_len = 16'd0;
			narrow(c);
			open_token(S_IDENT, 16'd1);
		end else if (is_num(c)) begin
			open_token(S_NUM, 16'd1);
		end else if (c == 8'h27) begin
			open_token(S_STR, 16'd0);
		end else if (c == "{") begin
			depth = 8'd1;
			trail = 16'd0;
			open_token(S_EXPR, 16'd0);
		end else if (is_op_byte(c)) begin
			open_token(S_OPS, 16'd1);
		end else begin
			case (c)
				"(": p = KIND_LPAREN;
				")": p = KIND_RPAREN;
				":": p = KIND_COLON;
				",": p = KIND_COMMA;
				";": p = KIND_SEMI;
				"=": p = KIND_ASSIGN;
				default: p = KIND_END;
			endcase
			if (p != KIND_END) put_token(p, line_n, col_n, 16'd1);
			col_n = inc16(col_n);
		end
	endtask

	task automatic body_byte(input logic [7:0] c);
		tok_len = inc16(tok_len);
		if (c == 8'h0A) begin
			line_n = inc16(line_n);
			col_n = 16'd1;
		end else begin
			col_n = inc16(col_n);
		end
	endtask

	task automatic scan_word(input logic [7:0] c, input logic e);
		if (done) return;
		run_q.delete();
		if (e || c == 8'h00) begin
			close_token();
			put_token(KIND_END, line_n, col_n, 16'd0);
			done = 1'b1;
		end else begin
			case (mode)
				S_IDENT:
					if (is_letter(c) || is_num(c) || c == "_" || c == "-") begin
						narrow(c);
						tok_len = inc16(tok_len);
						col_n = inc16(col_n);
					end else begin
						close_token();
						idle_byte(c);
					end
				S_NUM:
					if (is_num(c) || c == ".") begin
						tok_len = inc16(tok_len);
						col_n = inc16(col_n);
					end else begin
						close_token();
						idle_byte(c);
					end
				S_OPS:
					if (is_op_byte(c)) begin
						tok_len = inc16(tok_len);
						col_n = inc16(col_n);
					end else begin
						close_token();
						idle_byte(c);
					end
				S_STR:
					if (c == 8'h27) begin
						close_token();
						col_n = inc16(col_n);
					end else begin
						body_byte(c);
					end
				S_EXPR: begin
					if (c == "{") depth = depth == DEPTH_MAX ? depth : depth + 8'd1;
					else if (c == "}" && depth > 0) depth = depth - 8'd1;
					if (c == "}" && depth == 0) begin
						close_token();
						col_n = inc16(col_n);
					end else begin
						if (c == " " || (c >= 8'h09 && c <= 8'h0D)) trail = inc16(trail);
						else trail = 16'd0;
						body_byte(c);
					end
				end
				default: idle_byte(c);
			endcase
		end
		if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
		foreach (run_q[i]) token_q.push_back(run_q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			mode = S_IDLE;
			line_n = 16'd1;
			col_n = 16'd1;
			start_col = 16'd0;
			tok_len = 16'd0;
			depth = 8'd0;
			trail = 16'd0;
			cand = '1;
			done = 1'b0;
			token_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (token_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected token kind %0d line %0d col %0d len %0d",
							$realtime, token_kind, token_line, start_column, token_length);
				end else begin
					want = token_q.pop_front();
					if (want.kind != token_kind || want.line != token_line ||
						want.column != start_column || want.length != token_length ||
						want.last != last_of_run) begin
						errors++;
						if (errors <= 10)
							$display("%0t: token mismatch exp k%0d l%0d c%0d n%0d e%0d %s %0d %0d %0d %0d %0d",
								$realtime, want.kind, want.line, want.column, want.length,
								want.last, "got", token_kind, token_line, start_column,
								token_length, last_of_run);
					end
				end
			end
			if (in_valid && in_ready) scan_word(char_code, end_of_input);
			pending = token_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
module tb_top
	import dsl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           char_code = 8'h20;
	logic                 end_of_input = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [4:0]           token_kind;
	logic [OUT_WIDTH-1:0] token_line, start_column, token_length;
	logic                 last_of_run;
	logic                 word_taken = 1'b0;
	int                   errors, pending;
	int                   words_sent = 0;
	int                   quiet_cycles = 0;

	string kw_word [KW_COUNT] = '{"logic", "if", "else", "state", "transition", "context",
		"rule", "execute", "result", "terminate", "register", "constant", "push", "pop"};

	always #5 clk = ~clk;

	dsl_token_scanner uut (.*);

	token_checker u_checker (.*);

	always @(posedge clk) begin
		word_taken <= in_valid && in_ready;
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, one long hold-off to fill the queue
	initial begin
		int run_len, rx_cycles;
		logic rdy;
		run_len = 0;
		rx_cycles = 0;
		rdy = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles >= 2000 && rx_cycles < 2300) begin
				out_ready <= 1'b0;
			end else begin
				if (run_len == 0) begin
					rdy = $urandom_range(0, 2) != 0;
					run_len = rdy ? $urandom_range(1, 30) : pick_gap() + 1;
				end
				run_len--;
				out_ready <= rdy;
			end
		end
	end

	task automatic send_word(input logic [7:0] c, input logic e, input int gap);
		in_valid <= 1'b1;
		char_code <= c;
		end_of_input <= e;
		@(negedge clk);
		while (!word_taken) @(negedge clk);
		words_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_text(input string s, input logic bursty);
		for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0, bursty ? pick_gap() : 0);
	endtask

	function automatic string rand_chars(input string pool, input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
		return s;
	endfunction

	function automatic string make_fragment();
		string s;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 18) s = kw_word[$urandom_range(0, KW_COUNT - 1)];
		else if (r < 22) s = {kw_word[$urandom_range(0, KW_COUNT - 1)], rand_chars("a_-9", 1)};
		else if (r < 32) s = {rand_chars("abcxyzQZ_", 1), rand_chars("azAZ09_-", $urandom_range(0, 7))};
		else if (r < 40) s = rand_chars("0123456789.", $urandom_range(1, 6));
		else if (r < 48) s = rand_chars("<>!+-*/%&|", $urandom_range(1, 4));
		else if (r < 55) s = {"'", rand_chars("ab {}\n\t;", $urandom_range(0, 6)), "'"};
		else if (r < 64) s = {"{", rand_chars("a1 {}+\t\n\r\v\f", $urandom_range(0, 8)), "}}}}"};
		else if (r < 76) s = rand_chars("():,;=", 1);
		else if (r < 90) s = rand_chars(" \t\r\n", $urandom_range(1, 3));
		else if (r < 95) s = string'(8'($urandom_range(128, 255)));
		else s = string'(8'($urandom_range(1, 255)));
		return s;
	endfunction

	initial begin
		string tail;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_text({"if x_9- 3.1+-/'s\n t'{a{b}\t}(),:;=\n#", string'(8'hFF), string'(8'h80),
			"_"}, 1'b1);
		while (words_sent < 900) send_text(make_fragment(), 1'b1);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		send_text({"{", rand_chars("{", 300), "x  ", rand_chars("}", 300), " "}, 1'b0);
		while (words_sent < 1800) send_text(make_fragment(), 1'b1);
		if ($urandom_range(0, 1)) tail = "'open ";
		else tail = "{ x{ ";
		send_text(tail, 1'b1);
		if ($urandom_range(0, 1)) send_word(8'h00, 1'b0, 1);
		else send_word(8'($urandom_range(1, 255)), 1'b1, 1);
		send_word(8'h41, 1'b1, 0);
		send_word(8'h00, 1'b0, 0);
		send_word(8'h28, 1'b0, 0);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
